FILE: hdl/vigenere_letter_cipher_top_assert.svh
// ----------------------------------------------------------------------------
// vigenere letter cipher assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef VIGENERE_LETTER_CIPHER_TOP_ASSERT_SVH
`define VIGENERE_LETTER_CIPHER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define VLC_ASSERT(lbl, clk_i, rstn_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
    else $error("vlc assertion failed");
// implication checked on every clock edge outside reset
`define VLC_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("vlc assertion failed");
`else
`define VLC_ASSERT(lbl, clk_i, rstn_i, prop)
`define VLC_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

FILE: hdl/vlc_pkg.sv
// ----------------------------------------------------------------------------
// vlc_pkg
// Shared types and constants of the vigenere letter cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package vlc_pkg;

  // alphabet and key limits
  localparam int unsigned ALPHA      = 26;
  localparam int unsigned KEY_MAX    = 16;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned KEY_WORD_W = 40;
  localparam int unsigned KEY_LEN_W  = 5;
  localparam int unsigned KEY_POS_W  = 4;
  localparam int unsigned KEYS_PER_WORD = KEY_WORD_W / LETTER_W;

  // default queue depth between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd3;

  // reset values, key "KEY"
  localparam logic [KEY_WORD_W-1:0] KEY_LOW_RST  = 40'd24714;
  localparam logic [KEY_WORD_W-1:0] KEY_HIGH_RST = 40'd0;
  localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RST  = 5'd3;
  localparam logic                  MODE_RST     = 1'b0;

  // cipher modes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [KEY_WORD_W-1:0] key_low;
    logic [KEY_WORD_W-1:0] key_high;
    logic [KEY_LEN_W-1:0]  key_length;
    logic                  mode;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic [LETTER_W-1:0] shift;
    logic                mode;
  } item_t;

  // reduce a five-bit value modulo 26
  function automatic logic [LETTER_W-1:0] mod_alpha(input logic [LETTER_W-1:0] v);
    logic [LETTER_W-1:0] r;
    if (v >= LETTER_W'(ALPHA)) begin
      r = v - LETTER_W'(ALPHA);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/vlc_front.sv
// ----------------------------------------------------------------------------
// vlc_front
// Accepts letters, tracks the key position and picks the shift for each one.
// ----------------------------------------------------------------------------
`default_nettype none

module vlc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire vlc_pkg::cfg_t                 cfg,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [vlc_pkg::LETTER_W-1:0]  in_letter,
  input  wire logic                          in_message_start,
  input  wire logic                          q_full,
  output logic                               q_push,
  output vlc_pkg::item_t                     q_item
);

  localparam int unsigned LW  = vlc_pkg::LETTER_W;
  localparam int unsigned LNW = vlc_pkg::KEY_LEN_W;
  localparam int unsigned PW  = vlc_pkg::KEY_POS_W;
  localparam int unsigned KPW = vlc_pkg::KEYS_PER_WORD;

  logic [PW-1:0]  pos_r, pos_nxt;
  logic [LNW-1:0] eff_len;
  logic [LNW-1:0] cur_pos;
  logic [LNW-1:0] inc_pos;
  logic [LW-1:0]  key_letters [vlc_pkg::KEY_MAX];

  // unpack key letters from the two key words
  for (genvar g = 0; g < vlc_pkg::KEY_MAX; g++) begin : g_keys
    if (g < KPW) begin : g_low
      assign key_letters[g] = cfg.key_low[g*LW +: LW];
    end else begin : g_high
      assign key_letters[g] = cfg.key_high[(g-KPW)*LW +: LW];
    end
  end

  // effective key length, clamped to 1..KEY_MAX
  always_comb begin
    priority if (cfg.key_length == '0) begin
      eff_len = LNW'(1);
    end else if (cfg.key_length > LNW'(vlc_pkg::KEY_MAX)) begin
      eff_len = LNW'(vlc_pkg::KEY_MAX);
    end else begin
      eff_len = cfg.key_length;
    end
  end

  // position for this letter and the one after it
  always_comb begin
    if (in_message_start || ({1'b0, pos_r} >= eff_len)) begin
      cur_pos = '0;
    end else begin
      cur_pos = {1'b0, pos_r};
    end
    inc_pos = cur_pos + LNW'(1);
    if (inc_pos >= eff_len) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = inc_pos[PW-1:0];
    end
  end

  // handshake and classified item
  assign in_stall      = q_full;
  assign q_push        = in_valid && !q_full;
  assign q_item.letter = vlc_pkg::mod_alpha(in_letter);
  assign q_item.shift  = vlc_pkg::mod_alpha(key_letters[cur_pos[PW-1:0]]);
  assign q_item.mode   = cfg.mode;

  // key position advances on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/vlc_queue.sv
// ----------------------------------------------------------------------------
// vlc_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vigenere_letter_cipher_top_assert.svh"

module vlc_queue #(
  parameter int unsigned DEPTH = vlc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire vlc_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output vlc_pkg::item_t      q_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  vlc_pkg::item_t entry_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  // status
  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = entry_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // checks
  `VLC_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `VLC_ASSERT(a_no_overflow, clk, rst_n, !(push && full))
  `VLC_ASSERT(a_no_underflow, clk, rst_n, !(pop && !q_valid))
  `VLC_ASSERT_IMP(a_count_up, clk, rst_n, $past(rst_n) && $past(push) && !$past(pop), count_r == $past(count_r) + CW'(1))

endmodule

`default_nettype wire

FILE: hdl/vlc_back.sv
// ----------------------------------------------------------------------------
// vlc_back
// Applies the shift modulo 26 and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vlc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire vlc_pkg::item_t                q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [vlc_pkg::LETTER_W-1:0]       out_result_letter
);

  localparam int unsigned LW = vlc_pkg::LETTER_W;

  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] result_r, result_nxt;
  logic [LW:0]   sum;
  logic [LW:0]   diff;

  // shift forward or backward, wrapping at the alphabet size
  always_comb begin
    sum  = {1'b0, q_item.letter} + {1'b0, q_item.shift};
    diff = {1'b0, q_item.letter} - {1'b0, q_item.shift};
    unique case (q_item.mode)
      vlc_pkg::MODE_DECRYPT: begin
        if (q_item.letter >= q_item.shift) begin
          result_nxt = diff[LW-1:0];
        end else begin
          result_nxt = LW'(diff + (LW+1)'(vlc_pkg::ALPHA));
        end
      end
      default: begin
        if (sum >= (LW+1)'(vlc_pkg::ALPHA)) begin
          result_nxt = LW'(sum - (LW+1)'(vlc_pkg::ALPHA));
        end else begin
          result_nxt = sum[LW-1:0];
        end
      end
    endcase
  end

  // load output register when empty or being taken
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_letter = result_r;

endmodule

`default_nettype wire

FILE: hdl/vigenere_letter_cipher_top.sv
// ----------------------------------------------------------------------------
// vigenere_letter_cipher_top
// Vigenere letter cipher with programmable key of up to sixteen letters.
// ----------------------------------------------------------------------------
// Takes one letter (0 is A) per cycle while in_stall is low and returns one
// shifted letter for each, in order. A beat with message_start set uses key
// letter 0; the key position then advances and wraps at key_length (0 acts as
// 1, above 16 as 16). Letters and key letters of 26..31 are reduced modulo 26
// first. Each letter is held in the queue after the classifying front and
// then registered in the output register of the shift stage. After reset the
// key is "KEY" in encrypt mode. Write the configuration only while no letters
// are in flight.
`default_nettype none

module vigenere_letter_cipher_top #(
  parameter int unsigned QUEUE_DEPTH = vlc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_wr_en,
  input  wire logic [vlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vlc_pkg::KEY_WORD_W-1:0]   cfg_wdata,
  // input letters
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [vlc_pkg::LETTER_W-1:0]     in_letter,
  input  wire logic                             in_message_start,
  // result letters
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [vlc_pkg::LETTER_W-1:0]          out_result_letter
);

  vlc_pkg::cfg_t  cfg_r, cfg_nxt;
  vlc_pkg::item_t push_item;
  vlc_pkg::item_t q_item;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        vlc_pkg::REG_KEY_LOW:  cfg_nxt.key_low    = cfg_wdata;
        vlc_pkg::REG_KEY_HIGH: cfg_nxt.key_high   = cfg_wdata;
        vlc_pkg::REG_KEY_LEN:  cfg_nxt.key_length = cfg_wdata[vlc_pkg::KEY_LEN_W-1:0];
        vlc_pkg::REG_MODE:     cfg_nxt.mode       = cfg_wdata[0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_low    <= vlc_pkg::KEY_LOW_RST;
      cfg_r.key_high   <= vlc_pkg::KEY_HIGH_RST;
      cfg_r.key_length <= vlc_pkg::KEY_LEN_RST;
      cfg_r.mode       <= vlc_pkg::MODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify
  vlc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_letter        (in_letter),
    .in_message_start (in_message_start),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  // queue between front and back
  vlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // back: shift and output register
  vlc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_letter (out_result_letter)
  );

endmodule

`default_nettype wire
